[design/encoder_frame_qualify_select_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ENCODER_FRAME_QUALIFY_SELECT_MACROS_SVH
`define ENCODER_FRAME_QUALIFY_SELECT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge out of reset.
`define EFQS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("efqs assertion failed");

// Condition must never be seen out of reset.
`define EFQS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("efqs forbidden condition seen");

`else

`define EFQS_ASSERT(name, clk, rst_n, prop)
`define EFQS_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

[design/efqs_pkg.sv]
`timescale 1ns / 1ps

package efqs_pkg;

  localparam int FrameW  = 24;
  localparam int AngleW  = 12;
  localparam int StatusW = 5;
  localparam int CountW  = 3;
  localparam int CfgW    = 5;
  localparam int CfgIdxW = 2;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_FIRST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_SECOND = 2'd2;

  localparam logic [CountW-1:0]  MaxRetriesRst   = 3'd4;
  localparam logic [StatusW-1:0] StatusFirstRst  = 5'h10;
  localparam logic [StatusW-1:0] StatusSecondRst = 5'h13;
  localparam logic [CountW-1:0]  RejectMax       = 3'd7;
  localparam logic [AngleW-1:0]  HalfTurn        = 12'd2048;

  typedef struct packed {
    logic [AngleW-1:0]  angle;
    logic [StatusW-1:0] status;
    logic               parity_ok;
  } frame_fields_t;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [AngleW-1:0] distance;
  } pick_t;

  // W = frame << 1; angle W[23:12], status W[11:7], even parity bit W[6]
  function automatic frame_fields_t decode_frame(input logic [FrameW-1:0] frame);
    frame_fields_t f;
    logic [FrameW-1:0] w;
    w           = {frame[FrameW-2:0], 1'b0};
    f.angle     = w[23:12];
    f.status    = w[11:7];
    f.parity_ok = ((^w[23:7]) == w[6]);
    return f;
  endfunction

  // Distance around the 4096-count circle, 0..2048
  function automatic logic [AngleW-1:0] wrap_dist(input logic [AngleW-1:0] a,
                                                  input logic [AngleW-1:0] b);
    logic [AngleW-1:0] diff;
    diff = a - b;
    return (diff > HalfTurn) ? (AngleW'(0) - diff) : diff;
  endfunction

endpackage

[design/efqs_if.sv]
`timescale 1ns / 1ps

interface efqs_in_if import efqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              channel;
  logic [FrameW-1:0] frame;

  modport source (output valid, channel, frame, input ready);
  modport sink   (input valid, channel, frame, output ready);
endinterface

interface efqs_out_if import efqs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] angle;
  logic              out_channel;
  logic              forced;
  logic [AngleW-1:0] distance;

  modport source (output valid, angle, out_channel, forced, distance, input ready);
  modport sink   (input valid, angle, out_channel, forced, distance, output ready);
endinterface

[design/efqs_nearest.sv]
`timescale 1ns / 1ps

module efqs_nearest import efqs_pkg::*; #(
  parameter int READS = 3
) (
  input  logic [READS-1:0][AngleW-1:0] samples_i,
  input  logic [AngleW-1:0]            prev_i,
  output pick_t                        pick_o
);

  // Oldest sample first; strict compare keeps the earlier one on a tie.
  always_comb begin
    pick_t             best;
    logic [AngleW-1:0] d;
    best.angle    = samples_i[0];
    best.distance = wrap_dist(samples_i[0], prev_i);
    for (int i = 1; i < READS; i++) begin
      d = wrap_dist(samples_i[i], prev_i);
      if (d < best.distance) begin
        best.angle    = samples_i[i];
        best.distance = d;
      end
    end
    pick_o = best;
  end

endmodule

[design/encoder_frame_qualify_select.sv]
`timescale 1ns / 1ps
// Encoder frame qualify and select.
// Input channel in_if: one request carries a channel number and a 24-bit
// encoder frame. Each frame is checked for even parity and an allowed status
// code; after max_retries rejects in a row on a channel the next frame is
// taken unchecked and flagged forced. Every READS taken frames of a channel
// produce one request on out_if: the angle nearest (mod 4096) to that
// channel's last output, its distance, the channel and the forced flag.
// Config: cfg_we_i / cfg_idx_i / cfg_data_i write a register;
// write only while the block is idle.
// Timing: a frame is qualified and compared while it sits in the input
// register; its result (if any) is loaded into the result register, which
// drives out_if.valid. One frame per cycle is sustained while out_if is ready.
// Stall: while out_if holds a result that is not taken, the frame in the
// input register waits and in_if.ready drops; nothing is lost.
// Reset: all counters, flags and previous angles clear, registers return
// to 4 / 0x10 / 0x13. The sample store is not cleared; it is always
// written before it is read.

`include "encoder_frame_qualify_select_macros.svh"

module encoder_frame_qualify_select import efqs_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int READS    = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  efqs_in_if.sink            in_if,
  efqs_out_if.source         out_if
);

  localparam int ChW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IdxW   = (READS > 1) ? $clog2(READS) : 1;
  localparam int StoreD = (READS > 1) ? READS - 1 : 1;
  localparam int StW    = (StoreD > 1) ? $clog2(StoreD) : 1;

  // Config registers
  logic [CountW-1:0]  max_retries_q;
  logic [StatusW-1:0] status_first_q, status_second_q;

  // Input register
  logic              in_vld_q;
  logic              in_ch_q;
  logic [FrameW-1:0] in_frame_q;

  // Per-channel state
  logic [CountW-1:0] rej_q   [CHANNELS];
  logic [IdxW-1:0]   sidx_q  [CHANNELS];
  logic              fseen_q [CHANNELS];
  logic [AngleW-1:0] prev_q  [CHANNELS];
  // Earlier samples of the open group; the last one comes straight from the frame
  logic [AngleW-1:0] store_q [CHANNELS][StoreD];

  // Result register
  logic              out_vld_q;
  logic [AngleW-1:0] out_angle_q;
  logic              out_ch_q;
  logic              out_forced_q;
  logic [AngleW-1:0] out_dist_q;

  logic                        fire_s, ch_ok_s, forced_s, pass_s, take_s, last_s, emit_s;
  logic [ChW-1:0]              ch_idx;
  frame_fields_t               fields_s;
  logic [READS-1:0][AngleW-1:0] samples_s;
  pick_t                       pick_s;

  //--------------------------------------------------------------------------
  // Config port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q   <= MaxRetriesRst;
      status_first_q  <= StatusFirstRst;
      status_second_q <= StatusSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_RETRIES:   max_retries_q   <= cfg_data_i[CountW-1:0];
        CFG_STATUS_FIRST:  status_first_q  <= cfg_data_i[StatusW-1:0];
        CFG_STATUS_SECOND: status_second_q <= cfg_data_i[StatusW-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Handshake: the frame in the input register is processed when the result
  // register is free or being emptied this cycle.
  //--------------------------------------------------------------------------
  assign fire_s      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || fire_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_ch_q    <= in_if.channel;
      in_frame_q <= in_if.frame;
    end
  end

  //--------------------------------------------------------------------------
  // Qualify
  //--------------------------------------------------------------------------
  assign ch_idx   = ChW'(in_ch_q);
  assign ch_ok_s  = (int'(in_ch_q) < CHANNELS);
  assign fields_s = decode_frame(in_frame_q);
  assign forced_s = (rej_q[ch_idx] >= max_retries_q);
  assign pass_s   = fields_s.parity_ok &&
                    ((fields_s.status == status_first_q) ||
                     (fields_s.status == status_second_q));
  assign take_s   = forced_s || pass_s;
  assign last_s   = (sidx_q[ch_idx] == IdxW'(READS - 1));
  assign emit_s   = ch_ok_s && take_s && last_s;

  //--------------------------------------------------------------------------
  // Select nearest of the group
  //--------------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < READS - 1; r++) begin
      samples_s[r] = store_q[ch_idx][StW'(r)];
    end
    samples_s[READS-1] = fields_s.angle;
  end

  efqs_nearest #(
    .READS (READS)
  ) u_nearest (
    .samples_i (samples_s),
    .prev_i    (prev_q[ch_idx]),
    .pick_o    (pick_s)
  );

  //--------------------------------------------------------------------------
  // Per-channel state
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rej_q[c]   <= '0;
        sidx_q[c]  <= '0;
        fseen_q[c] <= 1'b0;
        prev_q[c]  <= '0;
      end
    end else if (fire_s && ch_ok_s) begin
      if (take_s) begin
        rej_q[ch_idx] <= '0;
        if (last_s) begin
          sidx_q[ch_idx]  <= '0;
          fseen_q[ch_idx] <= 1'b0;
          prev_q[ch_idx]  <= pick_s.angle;
        end else begin
          sidx_q[ch_idx] <= sidx_q[ch_idx] + IdxW'(1);
          if (forced_s) begin
            fseen_q[ch_idx] <= 1'b1;
          end
        end
      end else if (rej_q[ch_idx] != RejectMax) begin
        rej_q[ch_idx] <= rej_q[ch_idx] + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_s && ch_ok_s && take_s && !last_s) begin
      store_q[ch_idx][sidx_q[ch_idx][StW-1:0]] <= fields_s.angle;
    end
  end

  //--------------------------------------------------------------------------
  // Result register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire_s) begin
      out_vld_q <= emit_s;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_s && emit_s) begin
      out_angle_q  <= pick_s.angle;
      out_ch_q     <= in_ch_q;
      out_forced_q <= fseen_q[ch_idx] | forced_s;
      out_dist_q   <= pick_s.distance;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.angle       = out_angle_q;
  assign out_if.out_channel = out_ch_q;
  assign out_if.forced      = out_forced_q;
  assign out_if.distance    = out_dist_q;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  // A new result only appears after a frame was processed
  `EFQS_ASSERT(a_out_from_fire, clk_i, rst_ni,
               (out_vld_q && !$past(out_vld_q)) |-> $past(fire_s))
  // Wrapped distance never exceeds half a turn
  `EFQS_ASSERT_NEVER(a_dist_range, clk_i, rst_ni, out_vld_q && (out_dist_q > HalfTurn))
  // Emitted angle on channel 0 becomes its new reference
  `EFQS_ASSERT(a_prev_update, clk_i, rst_ni,
               (fire_s && emit_s && (ch_idx == '0)) |=> (prev_q[0] == out_angle_q))

endmodule

[test/tb_encoder_frame_qualify_select.sv]
`timescale 1ns / 1ps

module tb_encoder_frame_qualify_select import efqs_pkg::*; ();

  localparam int CHANNELS       = 2;
  localparam int READS          = 3;
  localparam int PHASE_REQUESTS = 129;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  // One selected angle as it leaves the block
  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic              out_channel;
    logic              forced;
    logic [AngleW-1:0] distance;
  } angle_pick_t;

  // Directed row; want is only used when typed is set
  typedef struct {
    logic              ch;
    logic [FrameW-1:0] frame;
    bit                typed;
    angle_pick_t       want;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  efqs_in_if  in_ch ();
  efqs_out_if out_ch ();

  encoder_frame_qualify_select #(
    .CHANNELS (CHANNELS),
    .READS    (READS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the register file
  logic [CountW-1:0]  retry_limit;
  logic [StatusW-1:0] status_a;
  logic [StatusW-1:0] status_b;

  // Mirror of the per-channel state
  logic [CountW-1:0] retry_run   [CHANNELS];
  int                taken_count [CHANNELS];
  logic [AngleW-1:0] sample_angle[CHANNELS][READS];
  logic              forced_flag [CHANNELS];
  logic [AngleW-1:0] last_angle  [CHANNELS];

  angle_pick_t expected_picks[$];
  angle_pick_t head_pick;
  frame_row_t  directed_rows[$];
  int          fail_count  = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          idle_on     = 1'b1;

  // Build a frame: angle in bits 22:11, status in 10:6, parity in 5,
  // don't-care bits 4:0 and the ignored top bit 23.
  function automatic logic [FrameW-1:0] make_frame(input logic [AngleW-1:0] ang,
                                                   input logic [StatusW-1:0] st,
                                                   input bit good,
                                                   input logic [4:0] lo,
                                                   input logic top);
    logic [FrameW-1:0] f;
    f    = {top, ang, st, 1'b0, lo};
    f[5] = (^f[22:6]) ^ ~good;
    return f;
  endfunction

  // Qualify one frame and, when a group of READS is complete, pick the
  // angle nearest the channel's last output. Returns 1 when a result is due.
  function automatic bit qualify_and_select(input logic ch, input logic [FrameW-1:0] fr,
                                            output angle_pick_t pick);
    logic [FrameW-1:0]  w;
    logic [AngleW-1:0]  ang;
    logic [StatusW-1:0] st;
    bit                 force_it;
    int                 d;
    int                 best_d;
    logic [AngleW-1:0]  best;
    pick     = '0;
    force_it = 1'b0;
    w        = {fr[FrameW-2:0], 1'b0};
    ang      = w[23:12];
    st       = w[11:7];
    if (retry_run[ch] >= retry_limit) begin
      force_it      = 1'b1;
      retry_run[ch] = '0;
    end else if (((^w[23:7]) == w[6]) && (st == status_a || st == status_b)) begin
      retry_run[ch] = '0;
    end else begin
      if (retry_run[ch] != RejectMax) retry_run[ch]++;
      return 1'b0;
    end
    sample_angle[ch][taken_count[ch]] = ang;
    if (force_it) forced_flag[ch] = 1'b1;
    taken_count[ch]++;
    if (taken_count[ch] < READS) return 1'b0;
    // strict compare: the earlier sample keeps a tie
    best_d = 4097;
    best   = '0;
    for (int i = 0; i < READS; i++) begin
      d = int'(sample_angle[ch][i]) - int'(last_angle[ch]);
      if (d > 2048) d -= 4096;
      if (d < -2048) d += 4096;
      if (d < 0) d = -d;
      if (d < best_d) begin
        best_d = d;
        best   = sample_angle[ch][i];
      end
    end
    pick.angle       = best;
    pick.out_channel = ch;
    pick.forced      = forced_flag[ch];
    pick.distance    = AngleW'(best_d);
    last_angle[ch]   = best;
    taken_count[ch]  = 0;
    forced_flag[ch]  = 1'b0;
    return 1'b1;
  endfunction

  // Offer one request after an optional idle burst, wait for the handshake,
  // then queue what it should produce.
  task automatic send_request(input logic ch, input logic [FrameW-1:0] fr,
                              input bit typed, input angle_pick_t want);
    int          gap;
    bit          due;
    angle_pick_t calc;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   = 1'b1;
    in_ch.channel = ch;
    in_ch.frame   = fr;
    do @(posedge clk_i); while (!in_ch.ready);
    due = qualify_and_select(ch, fr, calc);
    if (typed) expected_picks.push_back(want);
    else if (due) expected_picks.push_back(calc);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_RETRIES:   retry_limit = data[CountW-1:0];
      CFG_STATUS_FIRST:  status_a    = data[StatusW-1:0];
      CFG_STATUS_SECOND: status_b    = data[StatusW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CountW-1:0] mr, input logic [StatusW-1:0] sf,
                                input logic [StatusW-1:0] ss);
    write_reg(CFG_MAX_RETRIES, CfgW'(mr));
    write_reg(CFG_STATUS_FIRST, CfgW'(sf));
    write_reg(CFG_STATUS_SECOND, CfgW'(ss));
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Receiver: ready drops in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(1, 11) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Scoreboard: every result taken is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: angle %0d channel %0d", out_ch.angle, out_ch.out_channel);
        fail_count++;
      end else begin
        head_pick = expected_picks.pop_front();
        if (out_ch.angle !== head_pick.angle) begin
          $error("angle: expected %0d, got %0d", head_pick.angle, out_ch.angle);
          fail_count++;
        end
        if (out_ch.out_channel !== head_pick.out_channel) begin
          $error("out_channel: expected %0d, got %0d", head_pick.out_channel,
                 out_ch.out_channel);
          fail_count++;
        end
        if (out_ch.forced !== head_pick.forced) begin
          $error("forced: expected %0d, got %0d", head_pick.forced, out_ch.forced);
          fail_count++;
        end
        if (out_ch.distance !== head_pick.distance) begin
          $error("distance: expected %0d, got %0d", head_pick.distance, out_ch.distance);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[encoder_frame_qualify_select] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic              ch;
    logic [AngleW-1:0] ang;
    logic [StatusW-1:0] st;
    logic [FrameW-1:0] fr;
    logic [CountW-1:0] mr;
    logic [StatusW-1:0] sf;
    logic [StatusW-1:0] ss;
    int                kind;
    int                off;

    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.channel = 1'b0;
    in_ch.frame   = '0;
    out_ch.ready  = 1'b0;

    // Mirror comes up in the reset state
    retry_limit = MaxRetriesRst;
    status_a    = StatusFirstRst;
    status_b    = StatusSecondRst;
    for (int c = 0; c < CHANNELS; c++) begin
      retry_run[c]   = '0;
      taken_count[c] = 0;
      forced_flag[c] = 1'b0;
      last_angle[c]  = '0;
    end

    // Directed part, reset settings: retries 4, status 0x10 / 0x13.
    // Group on ch0 with a tie at distance 1 (0x001 vs 0xFFF): earlier wins.
    directed_rows.push_back('{1'b0, make_frame(12'h001, 5'h10, 1, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'hFFF, 5'h13, 1, 5'h00, 1'b1), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h800, 5'h10, 1, 5'h1F, 1'b0), 1,
                              angle_pick_t'{12'h001, 1'b0, 1'b0, 12'd1}});
    // Rejects mixed in (bad status, bad parity); half-turn distance 2048
    directed_rows.push_back('{1'b0, make_frame(12'h000, 5'h00, 1, 5'h0A, 1'b0), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h801, 5'h13, 1, 5'h15, 1'b1), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h801, 5'h10, 0, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h801, 5'h10, 1, 5'h1F, 1'b1), 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h801, 5'h13, 1, 5'h01, 1'b0), 1,
                              angle_pick_t'{12'h801, 1'b0, 1'b0, 12'd2048}});
    // Four rejects in a row on ch1, then an all-ones frame is forced in
    directed_rows.push_back('{1'b1, make_frame(12'h555, 5'h10, 0, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b1, make_frame(12'hAAA, 5'h1F, 1, 5'h1F, 1'b1), 0, '0});
    directed_rows.push_back('{1'b1, make_frame(12'h123, 5'h00, 1, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b1, make_frame(12'h3C3, 5'h11, 0, 5'h0F, 1'b1), 0, '0});
    directed_rows.push_back('{1'b1, 24'hFFFFFF, 0, '0});
    // ch0 sample in between: counts stay per channel
    directed_rows.push_back('{1'b0, make_frame(12'h123, 5'h10, 1, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b1, make_frame(12'h000, 5'h13, 1, 5'h00, 1'b0), 0, '0});
    directed_rows.push_back('{1'b1, make_frame(12'h7FF, 5'h10, 1, 5'h00, 1'b0), 1,
                              angle_pick_t'{12'h000, 1'b1, 1'b0 | 1'b1, 12'd0}});
    directed_rows.push_back('{1'b0, make_frame(12'hFFF, 5'h13, 1, 5'h15, 1'b1), 0, '0});
    directed_rows.push_back('{1'b0, 24'h000000, 0, '0});
    directed_rows.push_back('{1'b0, make_frame(12'h802, 5'h10, 1, 5'h0A, 1'b0), 0, '0});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r])
      send_request(directed_rows[r].ch, directed_rows[r].frame, directed_rows[r].typed,
                   directed_rows[r].want);

    // Random phases, each under its own register setting. The sender always
    // waits for the block to drain before reprogramming it.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin  // every frame forced
          mr = 3'd0; sf = 5'h00; ss = 5'h1F;
        end
        1: begin  // longest retry run
          mr = 3'd7; sf = 5'h1F; ss = 5'h00;
        end
        2: begin
          mr = 3'd1; sf = StatusFirstRst; ss = StatusSecondRst;
        end
        7: begin  // back to reset values, no idling to the end
          mr = MaxRetriesRst; sf = StatusFirstRst; ss = StatusSecondRst;
        end
        default: begin
          mr = CountW'($urandom_range(2, 6));
          sf = StatusW'($urandom_range(0, 31));
          ss = ($urandom_range(0, 3) == 0) ? sf : StatusW'($urandom_range(0, 31));
        end
      endcase
      settle();
      idle_on = (ph != 7);
      apply_settings(mr, sf, ss);

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        ch   = 1'($urandom_range(0, CHANNELS - 1));
        kind = $urandom_range(0, 99);
        st   = $urandom_range(0, 1) ? status_a : status_b;
        // Angle: anywhere, close to the last output (either side, so ties
        // show up), near the half turn, at the edges of the range or at 2048.
        case ($urandom_range(0, 3))
          0: ang = AngleW'($urandom_range(0, 4095));
          1: begin
            off = $urandom_range(0, 3);
            ang = $urandom_range(0, 1) ? last_angle[ch] + AngleW'(off)
                                       : last_angle[ch] - AngleW'(off);
          end
          2: ang = last_angle[ch] + HalfTurn + AngleW'($urandom_range(0, 2)) - AngleW'(1);
          default: begin
            case ($urandom_range(0, 2))
              0: ang = '0;
              1: ang = '1;
              default: ang = HalfTurn;
            endcase
          end
        endcase
        if (kind < 70)
          fr = make_frame(ang, st, 1, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        else if (kind < 80)  // bad parity
          fr = make_frame(ang, st, 0, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        else if (kind < 90)  // any status, good parity
          fr = make_frame(ang, 5'($urandom_range(0, 31)), 1, 5'($urandom_range(0, 31)),
                          1'($urandom_range(0, 1)));
        else
          fr = FrameW'($urandom_range(0, 24'hFFFFFF));
        send_request(ch, fr, 0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[encoder_frame_qualify_select] OK");
    end else begin
      $display("[encoder_frame_qualify_select] ERROR");
    end
    $finish;
  end

endmodule

[encoder_frame_qualify_select.f]
+incdir+design
design/efqs_pkg.sv
design/efqs_if.sv
design/efqs_nearest.sv
design/encoder_frame_qualify_select.sv
test/tb_encoder_frame_qualify_select.sv
